[hdl/gw_pkg.sv]
// ============================================================================
// Graph walker package
// Command and status codes, the command and result records, and the default
// slot count shared by the graph walker modules.
// ============================================================================
package gw_pkg;

    localparam int unsigned MAX_VERTICES_DEF = 16;

    localparam logic [7:0] LABEL_NONE = 8'h00;
    localparam logic [4:0] IDX_NONE   = 5'h1F;

    typedef enum logic [2:0] {
        CMD_INSERT      = 3'd0,
        CMD_DELETE      = 3'd1,
        CMD_ADD_EDGE    = 3'd2,
        CMD_REMOVE_EDGE = 3'd3,
        CMD_ADJACENT    = 3'd4,
        CMD_NEXT        = 3'd5,
        CMD_BFS         = 3'd6,
        CMD_DFS         = 3'd7
    } cmd_t;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_REJECT    = 2'd1,
        ST_FULL      = 2'd2,
        ST_NO_CHANGE = 2'd3
    } status_t;

    typedef struct packed {
        cmd_t       cmd;
        logic [7:0] label_a;
        logic [7:0] label_b;
        logic [4:0] after_index;
        logic [4:0] start_number;
    } req_t;

    typedef struct packed {
        status_t           status;
        logic              answer_flag;
        logic signed [4:0] vertex_index;
        logic [7:0]        vertex_label;
        logic [6:0]        edge_total;
        logic [4:0]        vertex_total;
        logic              last;
    } result_t;

endpackage

[hdl/gw_find.sv]
// ============================================================================
// Graph walker find-first unit
// Returns the lowest set bit of a slot vector at or above a start slot.
// Shared by label lookup, free-slot search, edge removal and the walks.
// ============================================================================
module gw_find #(
    parameter int unsigned MAX_VERTICES = gw_pkg::MAX_VERTICES_DEF
) (
    input  logic [MAX_VERTICES-1:0]         vec,
    input  logic [$clog2(MAX_VERTICES+1)-1:0] from,
    output logic                            found,
    output logic [$clog2(MAX_VERTICES)-1:0] idx
);

    localparam int unsigned N  = MAX_VERTICES;
    localparam int unsigned VW = $clog2(N);

    logic [N-1:0] masked;

    assign masked = vec & ({N{1'b1}} << from);

    always_comb begin
        found = 1'b0;
        idx   = '0;
        for (int i = N - 1; i >= 0; i--) begin
            if (masked[i]) begin
                found = 1'b1;
                idx   = VW'(i);
            end
        end
    end

endmodule

[hdl/gw_seq.sv]
// ============================================================================
// Graph walker sequencer
// Holds the slot table, adjacency matrix, counters and walk list, and steps
// one command at a time through the shared find-first unit.
// ============================================================================
module gw_seq #(
    parameter int unsigned MAX_VERTICES = gw_pkg::MAX_VERTICES_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  gw_pkg::req_t    in_req,
    input  logic            out_free,
    output logic            push,
    output gw_pkg::result_t push_data
);

    import gw_pkg::*;

    localparam int unsigned N  = MAX_VERTICES;
    localparam int unsigned VW = $clog2(N);
    localparam int unsigned CW = $clog2(N + 1);
    localparam int unsigned EW = $clog2(N * (N - 1) / 2 + 1);

    typedef enum logic [7:0] {
        S_IDLE      = 8'b0000_0001,
        S_FIND_A    = 8'b0000_0010,
        S_FIND_B    = 8'b0000_0100,
        S_EXEC      = 8'b0000_1000,
        S_DEL       = 8'b0001_0000,
        S_WALK_NEXT = 8'b0010_0000,
        S_WALK_SCAN = 8'b0100_0000,
        S_FLUSH     = 8'b1000_0000
    } state_t;

    state_t          state_reg, state_next;
    req_t            req_reg, req_next;
    logic [N-1:0]    match_a_reg, match_a_next;
    logic [N-1:0]    match_b_reg, match_b_next;
    logic [VW-1:0]   x_reg, x_next;
    logic            xf_reg, xf_next;
    logic [VW-1:0]   y_reg, y_next;
    logic            yf_reg, yf_next;
    logic [VW-1:0]   v_reg, v_next;
    logic [CW-1:0]   head_reg, head_next;
    logic [CW-1:0]   tail_reg, tail_next;
    logic [VW-1:0]   walk_reg [N];
    logic [VW-1:0]   walk_next [N];
    logic [7:0]      label_reg [N];
    logic [7:0]      label_next [N];
    logic [N-1:0]    valid_reg, valid_next;
    logic [N-1:0]    adj_reg [N];
    logic [N-1:0]    adj_next [N];
    logic [N-1:0]    visited_reg, visited_next;
    logic [EW-1:0]   ecount_reg, ecount_next;
    logic [CW-1:0]   vcount_reg, vcount_next;
    logic            pend_valid_reg, pend_valid_next;
    result_t         pend_reg, pend_next;

    logic [N-1:0]    f_vec;
    logic [CW-1:0]   f_from;
    logic            f_found;
    logic [VW-1:0]   f_idx;

    logic            can_emit;
    logic            emit;
    logic            flush;
    result_t         em;
    logic [CW-1:0]   next_from;
    logic [5:0]      after_p1;
    logic [5:0]      start_w;
    logic [VW-1:0]   start_idx;
    logic            start_ok;
    logic            is_bfs;
    logic [CW-1:0]   tail_m1;
    logic            has_edge;

    function automatic result_t make_result(
        input status_t       status,
        input logic          flag,
        input logic          has_idx,
        input logic [VW-1:0] idx,
        input logic [7:0]    label,
        input logic [EW-1:0] ecnt,
        input logic [CW-1:0] vcnt
    );
        logic [VW+4:0] idx_w;
        logic [EW+6:0] e_w;
        logic [CW+4:0] v_w;
        result_t       r;
        idx_w          = {5'b0, idx};
        e_w            = {7'b0, ecnt};
        v_w            = {5'b0, vcnt};
        r.status       = status;
        r.answer_flag  = flag;
        r.vertex_index = has_idx ? idx_w[4:0] : IDX_NONE;
        r.vertex_label = has_idx ? label : LABEL_NONE;
        r.edge_total   = e_w[6:0];
        r.vertex_total = v_w[4:0];
        r.last         = 1'b0;
        return r;
    endfunction

    gw_find #(
        .MAX_VERTICES(N)
    ) u_find (
        .vec  (f_vec),
        .from (f_from),
        .found(f_found),
        .idx  (f_idx)
    );

    // next-neighbour search start, clipped to the slot range
    assign after_p1 = {req_reg.after_index[4], req_reg.after_index} + 6'd1;
    always_comb begin
        if (after_p1[5]) begin
            next_from = '0;
        end else if (after_p1 >= 6'(N)) begin
            next_from = CW'(N);
        end else begin
            next_from = CW'(after_p1);
        end
    end

    assign start_w   = {1'b0, req_reg.start_number};
    assign start_idx = VW'(req_reg.start_number - 5'd1);
    assign start_ok  = (start_w != 6'd0) && (start_w <= 6'(N)) && valid_reg[start_idx];
    assign is_bfs    = (req_reg.cmd == CMD_BFS);
    assign tail_m1   = tail_reg - 1'b1;
    assign has_edge  = adj_reg[x_reg][y_reg];
    assign can_emit  = !pend_valid_reg || out_free;

    // shared unit operand select
    always_comb begin
        f_vec  = '0;
        f_from = '0;
        unique case (state_reg)
            S_FIND_A:    f_vec = match_a_reg;
            S_FIND_B:    f_vec = match_b_reg;
            S_EXEC: begin
                if (req_reg.cmd == CMD_INSERT) begin
                    f_vec = ~valid_reg;
                end else if (req_reg.cmd == CMD_NEXT) begin
                    f_vec  = adj_reg[x_reg] & valid_reg;
                    f_from = next_from;
                end
            end
            S_DEL:       f_vec = adj_reg[x_reg];
            S_WALK_SCAN: f_vec = adj_reg[v_reg] & ~visited_reg;
            default:     f_vec = '0;
        endcase
    end

    always_comb begin
        state_next      = state_reg;
        req_next        = req_reg;
        match_a_next    = match_a_reg;
        match_b_next    = match_b_reg;
        x_next          = x_reg;
        xf_next         = xf_reg;
        y_next          = y_reg;
        yf_next         = yf_reg;
        v_next          = v_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        walk_next       = walk_reg;
        label_next      = label_reg;
        valid_next      = valid_reg;
        adj_next        = adj_reg;
        visited_next    = visited_reg;
        ecount_next     = ecount_reg;
        vcount_next     = vcount_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        emit            = 1'b0;
        flush           = 1'b0;
        em              = make_result(ST_REJECT, 1'b0, 1'b0, '0, LABEL_NONE,
                                      ecount_reg, vcount_reg);
        in_ready        = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    req_next = in_req;
                    for (int s = 0; s < N; s++) begin
                        match_a_next[s] = valid_reg[s] && (label_reg[s] == in_req.label_a);
                        match_b_next[s] = valid_reg[s] && (label_reg[s] == in_req.label_b);
                    end
                    case (in_req.cmd) inside
                        CMD_INSERT, CMD_BFS, CMD_DFS: state_next = S_EXEC;
                        default:                      state_next = S_FIND_A;
                    endcase
                end
            end

            S_FIND_A: begin
                x_next  = f_idx;
                xf_next = f_found;
                case (req_reg.cmd) inside
                    CMD_ADD_EDGE, CMD_REMOVE_EDGE, CMD_ADJACENT: state_next = S_FIND_B;
                    default:                                     state_next = S_EXEC;
                endcase
            end

            S_FIND_B: begin
                y_next     = f_idx;
                yf_next    = f_found;
                state_next = S_EXEC;
            end

            S_EXEC: begin
                if (can_emit) begin
                    state_next = S_FLUSH;
                    unique case (req_reg.cmd)
                        CMD_INSERT: begin
                            emit = 1'b1;
                            if (req_reg.label_a == LABEL_NONE) begin
                                em = make_result(ST_REJECT, 1'b0, 1'b0, '0, LABEL_NONE,
                                                 ecount_reg, vcount_reg);
                            end else if (vcount_reg >= CW'(N) || !f_found) begin
                                em = make_result(ST_FULL, 1'b0, 1'b0, '0, LABEL_NONE,
                                                 ecount_reg, vcount_reg);
                            end else begin
                                label_next[f_idx] = req_reg.label_a;
                                valid_next[f_idx] = 1'b1;
                                adj_next[f_idx]   = '0;
                                for (int j = 0; j < N; j++) begin
                                    adj_next[j][f_idx] = 1'b0;
                                end
                                vcount_next = vcount_reg + 1'b1;
                                em = make_result(ST_DONE, 1'b0, 1'b1, f_idx,
                                                 req_reg.label_a, ecount_reg, vcount_next);
                            end
                        end
                        CMD_DELETE: begin
                            if (!xf_reg) begin
                                emit = 1'b1;
                            end else begin
                                state_next = S_DEL;
                            end
                        end
                        CMD_ADD_EDGE, CMD_REMOVE_EDGE, CMD_ADJACENT: begin
                            emit = 1'b1;
                            if (req_reg.label_a == req_reg.label_b || !xf_reg || !yf_reg) begin
                                em = make_result(ST_REJECT, 1'b0, 1'b0, '0, LABEL_NONE,
                                                 ecount_reg, vcount_reg);
                            end else if (req_reg.cmd == CMD_ADJACENT) begin
                                em = make_result(ST_DONE, has_edge, 1'b0, '0, LABEL_NONE,
                                                 ecount_reg, vcount_reg);
                            end else if ((req_reg.cmd == CMD_ADD_EDGE) == has_edge) begin
                                em = make_result(ST_NO_CHANGE, 1'b0, 1'b0, '0, LABEL_NONE,
                                                 ecount_reg, vcount_reg);
                            end else if (req_reg.cmd == CMD_ADD_EDGE) begin
                                adj_next[x_reg][y_reg] = 1'b1;
                                adj_next[y_reg][x_reg] = 1'b1;
                                ecount_next = ecount_reg + 1'b1;
                                em = make_result(ST_DONE, 1'b0, 1'b0, '0, LABEL_NONE,
                                                 ecount_next, vcount_reg);
                            end else begin
                                adj_next[x_reg][y_reg] = 1'b0;
                                adj_next[y_reg][x_reg] = 1'b0;
                                if (ecount_reg != '0) begin
                                    ecount_next = ecount_reg - 1'b1;
                                end
                                em = make_result(ST_DONE, 1'b0, 1'b0, '0, LABEL_NONE,
                                                 ecount_next, vcount_reg);
                            end
                        end
                        CMD_NEXT: begin
                            emit = 1'b1;
                            if (xf_reg) begin
                                em = make_result(ST_DONE, f_found, f_found, f_idx,
                                                 label_reg[f_idx], ecount_reg, vcount_reg);
                            end
                        end
                        CMD_BFS, CMD_DFS: begin
                            emit = 1'b1;
                            if (start_ok) begin
                                visited_next            = '0;
                                visited_next[start_idx] = 1'b1;
                                walk_next[0]            = start_idx;
                                head_next               = '0;
                                tail_next               = CW'(1);
                                em = make_result(ST_DONE, 1'b0, 1'b1, start_idx,
                                                 label_reg[start_idx], ecount_reg, vcount_reg);
                                state_next = S_WALK_NEXT;
                            end
                        end
                    endcase
                end
            end

            // drop one edge of the deleted vertex per cycle
            S_DEL: begin
                if (f_found) begin
                    adj_next[f_idx][x_reg] = 1'b0;
                    adj_next[x_reg][f_idx] = 1'b0;
                    if (ecount_reg != '0) begin
                        ecount_next = ecount_reg - 1'b1;
                    end
                end else if (can_emit) begin
                    valid_next[x_reg] = 1'b0;
                    if (vcount_reg != '0) begin
                        vcount_next = vcount_reg - 1'b1;
                    end
                    emit = 1'b1;
                    em   = make_result(ST_DONE, 1'b0, 1'b1, x_reg, label_reg[x_reg],
                                       ecount_reg, vcount_next);
                    state_next = S_FLUSH;
                end
            end

            // breadth first pops the queue head, depth first peeks the stack top
            S_WALK_NEXT: begin
                if (is_bfs) begin
                    if (head_reg == tail_reg) begin
                        state_next = S_FLUSH;
                    end else begin
                        v_next     = walk_reg[head_reg[VW-1:0]];
                        head_next  = head_reg + 1'b1;
                        state_next = S_WALK_SCAN;
                    end
                end else begin
                    if (tail_reg == '0) begin
                        state_next = S_FLUSH;
                    end else begin
                        v_next     = walk_reg[tail_m1[VW-1:0]];
                        state_next = S_WALK_SCAN;
                    end
                end
            end

            S_WALK_SCAN: begin
                if (!f_found) begin
                    if (!is_bfs) begin
                        tail_next = tail_m1;
                    end
                    state_next = S_WALK_NEXT;
                end else if (can_emit) begin
                    visited_next[f_idx] = 1'b1;
                    if (tail_reg < CW'(N)) begin
                        walk_next[tail_reg[VW-1:0]] = f_idx;
                        tail_next                   = tail_reg + 1'b1;
                    end
                    emit = 1'b1;
                    em   = make_result(ST_DONE, 1'b0, 1'b1, f_idx, label_reg[f_idx],
                                       ecount_reg, vcount_reg);
                    if (!is_bfs) begin
                        state_next = S_WALK_NEXT;
                    end
                end
            end

            // release the held result with last set
            S_FLUSH: begin
                flush = 1'b1;
                if (out_free) begin
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase

        if (emit) begin
            pend_valid_next = 1'b1;
            pend_next       = em;
        end
    end

    // one result is held back until it is known whether it is the last
    always_comb begin
        push           = (emit && pend_valid_reg) || (flush && out_free);
        push_data      = pend_reg;
        push_data.last = flush;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            valid_reg      <= '0;
            adj_reg        <= '{default: '0};
            visited_reg    <= '0;
            ecount_reg     <= '0;
            vcount_reg     <= '0;
            pend_valid_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            valid_reg      <= valid_next;
            adj_reg        <= adj_next;
            visited_reg    <= visited_next;
            ecount_reg     <= ecount_next;
            vcount_reg     <= vcount_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg     <= req_next;
        match_a_reg <= match_a_next;
        match_b_reg <= match_b_next;
        x_reg       <= x_next;
        xf_reg      <= xf_next;
        y_reg       <= y_next;
        yf_reg      <= yf_next;
        v_reg       <= v_next;
        head_reg    <= head_next;
        tail_reg    <= tail_next;
        walk_reg    <= walk_next;
        label_reg   <= label_next;
        pend_reg    <= pend_next;
    end

endmodule

[hdl/adjacency_matrix_graph_walker.sv]
// Undirected graph of up to MAX_VERTICES labelled slots kept as an adjacency
// bit matrix. One command is taken at a time; s_tready is low until its last
// result has entered the output register. Every command runs through one
// find-first unit under a small sequencer. Delete drops the edges of the
// vertex one at a time before it frees the slot. A walk is accepted, emits its
// start vertex, visits the rest by scanning rows (breadth first: one pop and
// one empty scan per queued vertex; depth first: one peek per step and one
// empty scan per backtrack), then makes a final check and releases its last
// result. Output backpressure can stall every command.
// ============================================================================
// Adjacency matrix graph walker
// Stream wrapper: unpacks the command, runs the sequencer, and holds each
// result in the output register until it is taken.
// ============================================================================
module adjacency_matrix_graph_walker #(
    parameter int unsigned MAX_VERTICES = gw_pkg::MAX_VERTICES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [7:0] label_a, [15:8] label_b, [20:16] after_index, [25:21] start_number
    input  logic [31:0] s_tdata,
    // [2:0] command
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [1:0] status, [2] answer_flag, [7:3] vertex_index, [15:8] vertex_label,
    // [22:16] edge_total, [27:23] vertex_total
    output logic [31:0] m_tdata,
    output logic        m_tlast
);

    import gw_pkg::*;

    req_t    req;
    logic    out_free;
    logic    push;
    result_t push_data;
    logic    m_tvalid_reg, m_tvalid_next;
    result_t out_reg;

    always_comb begin
        req.cmd          = cmd_t'(s_tuser);
        req.label_a      = s_tdata[7:0];
        req.label_b      = s_tdata[15:8];
        req.after_index  = s_tdata[20:16];
        req.start_number = s_tdata[25:21];
    end

    gw_seq #(
        .MAX_VERTICES(MAX_VERTICES)
    ) u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_req   (req),
        .out_free (out_free),
        .push     (push),
        .push_data(push_data)
    );

    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (push) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // hold the transaction until taken
    always_ff @(posedge aclk) begin
        if (push) begin
            out_reg <= push_data;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = out_reg.last;
    assign m_tdata  = {4'b0, out_reg.vertex_total, out_reg.edge_total, out_reg.vertex_label,
                       out_reg.vertex_index, out_reg.answer_flag, out_reg.status};

endmodule

[dv/testbench.sv]
// ----------------------------------------------------------------------------
// Graph walker testbench
// Drives graph commands into the adjacency matrix walker over the input
// stream and checks every result transaction against an in-bench model of the
// graph: vertex table, adjacency rows and breadth-first and depth-first walks.
// Both stream sides idle and stall at random. One phase holds off the result
// side long enough to stall the input.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import gw_pkg::*;

    localparam int NV = MAX_VERTICES_DEF;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic [2:0]  s_tuser  = CMD_INSERT;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tlast;

    adjacency_matrix_graph_walker dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    // Graph model
    logic [7:0]  g_label [NV];
    bit          g_used  [NV];
    logic [15:0] g_row   [NV];
    int          g_edges;
    int          g_verts;
    logic [15:0] g_seen;

    result_t step_replies [$];
    result_t reply_queue  [$];

    bit throttle        = 1'b0;
    int hold_off_cycles = 0;
    int stall_left      = 0;
    int items_sent      = 0;
    int fail_count      = 0;
    int mismatch_count  = 0;

    function automatic int pick_gap();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int find_slot(logic [7:0] lbl);
        for (int s = 0; s < NV; s++)
            if (g_used[s] && g_label[s] == lbl)
                return s;
        return -1;
    endfunction

    function automatic void add_reply(status_t st, logic flag, int idx);
        result_t r;
        r.status       = st;
        r.answer_flag  = flag;
        r.vertex_index = idx[4:0];
        r.vertex_label = LABEL_NONE;
        if (idx >= 0)
            r.vertex_label = g_label[idx];
        r.edge_total   = g_edges[6:0];
        r.vertex_total = g_verts[4:0];
        r.last         = 1'b0;
        step_replies.push_back(r);
    endfunction

    function automatic int next_unseen(int v, int from);
        for (int j = from; j < NV; j++)
            if (g_row[v][j] && !g_seen[j])
                return j;
        return -1;
    endfunction

    function automatic void mark_visited(int s);
        g_seen[s] = 1'b1;
        add_reply(ST_DONE, 1'b0, s);
    endfunction

    function automatic void walk_breadth(int start);
        int order [NV];
        int head;
        int tail;
        int v;
        int n;
        head = 0;
        tail = 1;
        order[0] = start;
        mark_visited(start);
        while (head < tail) begin
            v = order[head];
            head++;
            n = next_unseen(v, 0);
            while (n >= 0) begin
                if (tail < NV) begin
                    order[tail] = n;
                    tail++;
                end
                mark_visited(n);
                n = next_unseen(v, n + 1);
            end
        end
    endfunction

    function automatic void walk_depth(int start);
        int stk_v   [NV];
        int stk_pos [NV];
        int depth;
        int n;
        stk_v[0]   = start;
        stk_pos[0] = 0;
        depth      = 1;
        mark_visited(start);
        while (depth > 0) begin
            n = next_unseen(stk_v[depth-1], stk_pos[depth-1]);
            if (n < 0) begin
                depth--;
            end else begin
                // resume this vertex past n when we backtrack to it
                stk_pos[depth-1] = n + 1;
                mark_visited(n);
                if (depth < NV) begin
                    stk_v[depth]   = n;
                    stk_pos[depth] = 0;
                    depth++;
                end
            end
        end
    endfunction

    // Update the graph model for one accepted command and queue its replies.
    function automatic void apply_command(cmd_t c, logic [7:0] a, logic [7:0] b,
                                          logic [4:0] after, logic [4:0] start);
        int      x;
        int      y;
        int      s;
        int      from;
        int      found;
        logic    has;
        result_t r;
        step_replies.delete();
        case (c)
            CMD_INSERT: begin
                if (a == LABEL_NONE) begin
                    add_reply(ST_REJECT, 1'b0, -1);
                end else if (g_verts >= NV) begin
                    add_reply(ST_FULL, 1'b0, -1);
                end else begin
                    s = 0;
                    while (s < NV && g_used[s])
                        s++;
                    g_label[s] = a;
                    g_used[s]  = 1'b1;
                    g_row[s]   = '0;
                    for (int j = 0; j < NV; j++)
                        g_row[j][s] = 1'b0;
                    g_verts++;
                    add_reply(ST_DONE, 1'b0, s);
                end
            end
            CMD_DELETE: begin
                x = find_slot(a);
                if (x < 0) begin
                    add_reply(ST_REJECT, 1'b0, -1);
                end else begin
                    for (int j = 0; j < NV; j++) begin
                        if (g_row[x][j]) begin
                            g_row[j][x] = 1'b0;
                            if (g_edges > 0)
                                g_edges--;
                        end
                    end
                    g_row[x]  = '0;
                    g_used[x] = 1'b0;
                    if (g_verts > 0)
                        g_verts--;
                    add_reply(ST_DONE, 1'b0, x);
                end
            end
            CMD_ADD_EDGE, CMD_REMOVE_EDGE, CMD_ADJACENT: begin
                x = find_slot(a);
                y = find_slot(b);
                if (a == b || x < 0 || y < 0) begin
                    add_reply(ST_REJECT, 1'b0, -1);
                end else begin
                    has = g_row[x][y];
                    if (c == CMD_ADJACENT) begin
                        add_reply(ST_DONE, has, -1);
                    end else if (c == CMD_ADD_EDGE) begin
                        if (has) begin
                            add_reply(ST_NO_CHANGE, 1'b0, -1);
                        end else begin
                            g_row[x][y] = 1'b1;
                            g_row[y][x] = 1'b1;
                            g_edges++;
                            add_reply(ST_DONE, 1'b0, -1);
                        end
                    end else if (!has) begin
                        add_reply(ST_NO_CHANGE, 1'b0, -1);
                    end else begin
                        g_row[x][y] = 1'b0;
                        g_row[y][x] = 1'b0;
                        if (g_edges > 0)
                            g_edges--;
                        add_reply(ST_DONE, 1'b0, -1);
                    end
                end
            end
            CMD_NEXT: begin
                x = find_slot(a);
                if (x < 0) begin
                    add_reply(ST_REJECT, 1'b0, -1);
                end else begin
                    from = $signed(after) + 1;
                    if (from < 0)
                        from = 0;
                    found = -1;
                    for (int j = from; j < NV; j++) begin
                        if (found < 0 && g_used[j] && g_row[x][j])
                            found = j;
                    end
                    add_reply(ST_DONE, found >= 0, found);
                end
            end
            default: begin
                if (start == 0 || start > NV || !g_used[start - 1]) begin
                    add_reply(ST_REJECT, 1'b0, -1);
                end else begin
                    g_seen = '0;
                    if (c == CMD_BFS)
                        walk_breadth(int'(start) - 1);
                    else
                        walk_depth(int'(start) - 1);
                end
            end
        endcase
        foreach (step_replies[i]) begin
            r = step_replies[i];
            r.last = (i == step_replies.size() - 1);
            reply_queue.push_back(r);
        end
    endfunction

    function automatic int any_used_slot();
        int s;
        do
            s = $urandom_range(0, NV - 1);
        while (!g_used[s]);
        return s;
    endfunction

    // Mostly a label that exists, sometimes any byte.
    function automatic logic [7:0] pick_label();
        if (g_verts > 0 && $urandom_range(0, 9) < 8)
            return g_label[any_used_slot()];
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [4:0] pick_start();
        if (g_verts > 0 && $urandom_range(0, 9) < 8)
            return 5'(any_used_slot() + 1);
        return 5'($urandom_range(0, 31));
    endfunction

    task automatic issue(cmd_t c, logic [7:0] a, logic [7:0] b,
                         logic [4:0] after, logic [4:0] start);
        int gap;
        s_tuser  <= c;
        s_tdata  <= {6'b0, start, after, b, a};
        s_tvalid <= 1'b1;
        do
            @(posedge aclk);
        while (!s_tready);
        apply_command(c, a, b, after, start);
        items_sent++;
        @(negedge aclk);
        if (throttle && $urandom_range(0, 1) == 0) begin
            gap = pick_gap();
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
    endtask

    task automatic issue_random();
        issue(cmd_t'(3'($urandom_range(0, 7))), pick_label(), pick_label(),
              5'($urandom_range(0, 31)), pick_start());
    endtask

    task automatic test_directed_cases();
        throttle = 1'b0;
        issue(CMD_INSERT,      8'h00, 8'h00, 5'd0,  5'd0);  // label zero
        issue(CMD_DELETE,      8'h55, 8'h00, 5'd0,  5'd0);  // empty graph
        issue(CMD_BFS,         8'h00, 8'h00, 5'd0,  5'd1);  // free start slot
        issue(CMD_INSERT,      8'hFF, 8'h00, 5'd0,  5'd0);
        issue(CMD_INSERT,      8'h01, 8'h00, 5'd0,  5'd0);
        issue(CMD_INSERT,      8'h01, 8'h00, 5'd0,  5'd0);  // duplicate label
        issue(CMD_ADD_EDGE,    8'hFF, 8'h01, 5'd0,  5'd0);
        issue(CMD_ADD_EDGE,    8'h01, 8'hFF, 5'd0,  5'd0);  // already there
        issue(CMD_ADD_EDGE,    8'h01, 8'h01, 5'd0,  5'd0);  // same label
        issue(CMD_ADJACENT,    8'hFF, 8'h01, 5'd0,  5'd0);
        issue(CMD_ADJACENT,    8'hFF, 8'h77, 5'd0,  5'd0);  // unknown label
        issue(CMD_INSERT,      8'h80, 8'h00, 5'd0,  5'd0);
        issue(CMD_ADD_EDGE,    8'h80, 8'h01, 5'd0,  5'd0);
        issue(CMD_NEXT,        8'hFF, 8'h00, 5'h1F, 5'd0);  // after -1
        issue(CMD_NEXT,        8'h01, 8'h00, 5'h10, 5'd0);  // most negative
        issue(CMD_NEXT,        8'h01, 8'h00, 5'd0,  5'd0);
        issue(CMD_NEXT,        8'h01, 8'h00, 5'd15, 5'd0);  // past the end
        issue(CMD_NEXT,        8'h42, 8'h00, 5'd0,  5'd0);
        issue(CMD_REMOVE_EDGE, 8'hFF, 8'h80, 5'd0,  5'd0);  // missing edge
        issue(CMD_BFS,         8'h00, 8'h00, 5'd0,  5'd1);
        issue(CMD_DFS,         8'h00, 8'h00, 5'd0,  5'd3);  // isolated vertex
        issue(CMD_DFS,         8'h00, 8'h00, 5'd0,  5'd0);
        issue(CMD_BFS,         8'h00, 8'h00, 5'd0,  5'd17);
        issue(CMD_DFS,         8'h00, 8'h00, 5'd0,  5'd31);
        issue(CMD_REMOVE_EDGE, 8'h01, 8'h80, 5'd0,  5'd0);
        issue(CMD_DELETE,      8'h01, 8'h00, 5'd0,  5'd0);  // drops an edge
        issue(CMD_DELETE,      8'h01, 8'h00, 5'd0,  5'd0);  // now the duplicate
        issue(CMD_ADJACENT,    8'hFF, 8'h80, 5'd0,  5'd0);
    endtask

    task automatic test_output_backpressure();
        throttle = 1'b0;
        repeat (4)
            issue(CMD_INSERT, 8'($urandom_range(1, 255)), 8'h00, 5'd0, 5'd0);
        repeat (6)
            issue(CMD_ADD_EDGE, pick_label(), pick_label(), 5'd0, 5'd0);
        hold_off_cycles = 400;
        issue(CMD_BFS, 8'h00, 8'h00, 5'd0, 5'd1);
        issue(CMD_DFS, 8'h00, 8'h00, 5'd0, pick_start());
        repeat (8)
            issue_random();
    endtask

    task automatic test_random_graphs();
        int size;
        int floor_verts;
        while (items_sent < 340) begin
            throttle = ($urandom_range(0, 3) != 0);
            size = ($urandom_range(0, 5) == 0) ? NV : $urandom_range(2, 8);
            while (g_verts < size) begin
                if (g_verts > 0 && $urandom_range(0, 9) == 0)
                    issue(CMD_INSERT, pick_label(), 8'h00, 5'd0, 5'd0);
                else
                    issue(CMD_INSERT, 8'($urandom_range(1, 255)), 8'h00, 5'd0, 5'd0);
            end
            if (size == NV)
                issue(CMD_INSERT, 8'($urandom_range(1, 255)), 8'h00, 5'd0, 5'd0);
            repeat (size * 2)
                issue(CMD_ADD_EDGE, pick_label(), pick_label(), 5'd0, 5'd0);
            repeat ($urandom_range(8, 16))
                issue_random();
            repeat ($urandom_range(2, 4))
                issue($urandom_range(0, 1) ? CMD_BFS : CMD_DFS,
                      8'h00, 8'h00, 5'd0, pick_start());
            floor_verts = $urandom_range(0, 3);
            while (g_verts > floor_verts)
                issue(CMD_DELETE, g_label[any_used_slot()], 8'h00, 5'd0, 5'd0);
        end
    endtask

    // Result side ready: random stalls, or one long hold-off on request.
    always @(negedge aclk) begin
        if (hold_off_cycles != 0) begin
            stall_left = hold_off_cycles;
            hold_off_cycles = 0;
        end else if (stall_left == 0 && throttle && $urandom_range(0, 3) == 0) begin
            stall_left = pick_gap();
        end
        if (stall_left != 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.status       = status_t'(m_tdata[1:0]);
            got.answer_flag  = m_tdata[2];
            got.vertex_index = m_tdata[7:3];
            got.vertex_label = m_tdata[15:8];
            got.edge_total   = m_tdata[22:16];
            got.vertex_total = m_tdata[27:23];
            got.last         = m_tlast;
            if (reply_queue.size() == 0) begin
                fail_count++;
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: result transaction with nothing pending: %p", $time, got);
            end else begin
                want = reply_queue.pop_front();
                if (got !== want) begin
                    fail_count++;
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: result mismatch\n  expected %p\n  actual   %p",
                                 $time, want, got);
                end
            end
        end
    end

    initial begin
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_directed_cases();
        test_output_backpressure();
        test_random_graphs();
        s_tvalid <= 1'b0;
        while (reply_queue.size() != 0)
            @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial begin
        #20ms;
        $display("Regression FAIL");
        $finish;
    end

endmodule

[sim.f]
hdl/gw_pkg.sv
hdl/gw_find.sv
hdl/gw_seq.sv
hdl/adjacency_matrix_graph_walker.sv
dv/testbench.sv
